// ===== rtl/mixq_pkg.sv =====
package mixq_pkg;

   // bus depth and derived address width
   localparam int FRAMES = 65536;
   localparam int ADDR_W = $clog2(FRAMES);

   // field widths
   localparam int IDX_W      = 16;
   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 24;
   localparam int GAIN_W     = 16;
   localparam int DITHER_W   = 8;
   localparam int DSUM_W     = DITHER_W + 1;
   localparam int PCM_W      = 24;
   localparam int PEAK_W     = 39;
   localparam int BUS_W      = 40;
   localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
   localparam int SUM_W      = BUS_W + 1;
   localparam int V_W        = 64;
   localparam int COUNT_W    = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // fixed-point shifts
   localparam int GAIN_SHIFT   = 9;
   localparam int FRAC_W       = 28;
   localparam int DITHER_SHIFT = 20;
   localparam int SHIFT_24     = 23;
   localparam int SHIFT_16     = 15;

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MIX    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EXPORT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_MODE  = 1'd1;

   // numeric limits
   localparam logic signed [BUS_W-1:0] BUS_MAX  = {1'b0, {(BUS_W-1){1'b1}}};
   localparam logic signed [BUS_W-1:0] BUS_MIN  = {1'b1, {(BUS_W-1){1'b0}}};
   localparam logic [PEAK_W-1:0]       PEAK_MAX = {PEAK_W{1'b1}};
   localparam logic signed [PROD_W-1:0] GAIN_ROUND = PROD_W'((1 << GAIN_SHIFT) - 1);
   localparam logic signed [V_W-1:0]   FRAC_ROUND = V_W'((64'd1 << FRAC_W) - 64'd1);
   localparam logic signed [PCM_W-1:0] SCALE_24 = PCM_W'(8388607);
   localparam logic signed [PCM_W-1:0] SCALE_16 = PCM_W'(32767);
   localparam logic signed [V_W-1:0]   LIM_24   = V_W'(SCALE_24) <<< FRAC_W;
   localparam logic signed [V_W-1:0]   LIM_16   = V_W'(SCALE_16) <<< FRAC_W;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd;
      logic st1;
      logic st2;
      logic fin;
      logic sweep;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] req_cmd;
      logic             req_in_range;
      logic             sweep_last;
   } dp_status_type;

endpackage

// ===== rtl/mixq_ctrl.sv =====
module mixq_ctrl
   import mixq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type stat,
   output ctl_cmd_type   ctl
);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_CALC1  = 7'b0001000,
      ST_CALC2  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_CLEAR  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ctl.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
            if (req_valid) begin
               if (stat.req_cmd == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if ((stat.req_cmd inside {CMD_MIX, CMD_EXPORT}) &&
                            stat.req_in_range) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            ctl.rd   = 1'b1;
            state_in = ST_CALC1;
         end
         ST_CALC1: begin
            ctl.st1  = 1'b1;
            state_in = ST_CALC2;
         end
         ST_CALC2: begin
            ctl.st2  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (slot_free) begin
               ctl.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            ctl.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_FINISH;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/mixq_datapath.sv =====
module mixq_datapath
   import mixq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_cmd_type                 ctl,
   output dp_status_type               stat,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic [CMD_W-1:0]            req_command,
   input  logic [IDX_W-1:0]            req_frame_index,
   input  logic signed [SAMPLE_W-1:0]  req_left_in,
   input  logic signed [SAMPLE_W-1:0]  req_right_in,
   input  logic [GAIN_W-1:0]           req_gain,
   input  logic signed [DITHER_W-1:0]  req_dither_left_a,
   input  logic signed [DITHER_W-1:0]  req_dither_left_b,
   input  logic signed [DITHER_W-1:0]  req_dither_right_a,
   input  logic signed [DITHER_W-1:0]  req_dither_right_b,
   output logic signed [PCM_W-1:0]     rsp_pcm_left,
   output logic signed [PCM_W-1:0]     rsp_pcm_right,
   output logic [PEAK_W-1:0]           rsp_peak_left,
   output logic [PEAK_W-1:0]           rsp_peak_right,
   output logic                        rsp_status
);

   function automatic logic signed [BUS_W-1:0] mix_sum(
      input logic signed [BUS_W-1:0]  acc,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] biased;
      logic signed [PROD_W-1:0] quot;
      logic signed [SUM_W-1:0]  sum;
      begin
         // divide by 512 truncating toward zero
         biased = prod + (prod[PROD_W-1] ? GAIN_ROUND : '0);
         quot   = biased >>> GAIN_SHIFT;
         sum    = SUM_W'(acc) + SUM_W'(quot);
         if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            return sum[SUM_W-1] ? BUS_MIN : BUS_MAX;
         end
         return sum[BUS_W-1:0];
      end
   endfunction

   function automatic logic signed [V_W-1:0] scaled(
      input logic signed [BUS_W-1:0]  s,
      input logic signed [DSUM_W-1:0] d,
      input logic                     depth16
   );
      logic signed [V_W-1:0] s64;
      logic signed [V_W-1:0] sh;
      begin
         // scale is 2^k - 1, so s * scale is a shift and a subtract
         s64 = V_W'(s);
         sh  = depth16 ? (s64 <<< SHIFT_16) : (s64 <<< SHIFT_24);
         return sh - s64 + (V_W'(d) <<< DITHER_SHIFT);
      end
   endfunction

   function automatic logic signed [PCM_W-1:0] quantize(
      input logic signed [V_W-1:0] v,
      input logic                  depth16
   );
      logic signed [V_W-1:0]   lim;
      logic signed [PCM_W-1:0] scale;
      logic signed [V_W-1:0]   biased;
      logic signed [V_W-1:0]   q;
      begin
         lim    = depth16 ? LIM_16 : LIM_24;
         scale  = depth16 ? SCALE_16 : SCALE_24;
         biased = v + (v[V_W-1] ? FRAC_ROUND : '0);
         q      = biased >>> FRAC_W;
         if (v > lim) return scale;
         if (v < -lim) return -scale;
         return q[PCM_W-1:0];
      end
   endfunction

   function automatic logic [PEAK_W-1:0] magnitude(input logic signed [BUS_W-1:0] s);
      logic signed [BUS_W-1:0] neg;
      begin
         neg = -s;
         if (s == BUS_MIN) return PEAK_MAX;
         if (s[BUS_W-1]) return neg[PEAK_W-1:0];
         return s[PEAK_W-1:0];
      end
   endfunction

   // configuration
   logic [COUNT_W-1:0] frame_count_ff;
   logic               depth_mode_ff;

   // latched item
   logic [CMD_W-1:0]           cmd_ff;
   logic                       in_range_ff;
   logic [ADDR_W-1:0]          addr_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic signed [DSUM_W-1:0]   dith_l_ff, dith_r_ff;

   // bus stores
   logic signed [BUS_W-1:0] left_mem  [FRAMES];
   logic signed [BUS_W-1:0] right_mem [FRAMES];
   logic signed [BUS_W-1:0] rd_l_ff, rd_r_ff;
   logic [ADDR_W-1:0]       sweep_ff;
   logic                    sweep_last;
   logic                    mix_we;

   // arithmetic stages
   logic signed [PROD_W-1:0] prod_l_ff, prod_r_ff;
   logic signed [V_W-1:0]    v_l_ff, v_r_ff;
   logic [PEAK_W-1:0]        mag_l_ff, mag_r_ff;
   logic signed [BUS_W-1:0]  sum_l_ff, sum_r_ff;
   logic signed [PCM_W-1:0]  pcm_l_ff, pcm_r_ff;

   // peaks and result
   logic [PEAK_W-1:0]       peak_l_ff, peak_r_ff, peak_l_in, peak_r_in;
   logic                    exported;
   logic                    req_in_range;
   logic signed [PCM_W-1:0] rsp_pcm_left_ff, rsp_pcm_right_ff;
   logic [PEAK_W-1:0]       rsp_peak_left_ff, rsp_peak_right_ff;
   logic                    rsp_status_ff;

   assign req_in_range = ({1'b0, req_frame_index} < frame_count_ff) &&
                         (32'(req_frame_index) < FRAMES);
   assign sweep_last   = (sweep_ff == ADDR_W'(FRAMES - 1));

   assign stat.req_cmd      = req_command;
   assign stat.req_in_range = req_in_range;
   assign stat.sweep_last   = sweep_last;

   assign exported = (cmd_ff == CMD_EXPORT) && in_range_ff;
   assign mix_we   = ctl.fin && (cmd_ff == CMD_MIX) && in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         depth_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_COUNT: frame_count_ff <= csr_data[COUNT_W-1:0];
            REG_DEPTH_MODE:  depth_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff      <= req_command;
         in_range_ff <= req_in_range;
         addr_ff     <= ADDR_W'(req_frame_index);
         left_ff     <= req_left_in;
         right_ff    <= req_right_in;
         gain_ff     <= req_gain;
         dith_l_ff   <= DSUM_W'(req_dither_left_a) + DSUM_W'(req_dither_left_b);
         dith_r_ff   <= DSUM_W'(req_dither_right_a) + DSUM_W'(req_dither_right_b);
      end
   end

   // sweep address wraps to zero so every pass starts at the bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (ctl.sweep) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sweep) begin
         left_mem[sweep_ff]  <= '0;
         right_mem[sweep_ff] <= '0;
      end else if (mix_we) begin
         left_mem[addr_ff]  <= sum_l_ff;
         right_mem[addr_ff] <= sum_r_ff;
      end
      if (ctl.rd) begin
         rd_l_ff <= left_mem[addr_ff];
         rd_r_ff <= right_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.st1) begin
         prod_l_ff <= PROD_W'(left_ff) * PROD_W'($signed({1'b0, gain_ff}));
         prod_r_ff <= PROD_W'(right_ff) * PROD_W'($signed({1'b0, gain_ff}));
         v_l_ff    <= scaled(rd_l_ff, dith_l_ff, depth_mode_ff);
         v_r_ff    <= scaled(rd_r_ff, dith_r_ff, depth_mode_ff);
         mag_l_ff  <= magnitude(rd_l_ff);
         mag_r_ff  <= magnitude(rd_r_ff);
      end
      if (ctl.st2) begin
         sum_l_ff <= mix_sum(rd_l_ff, prod_l_ff);
         sum_r_ff <= mix_sum(rd_r_ff, prod_r_ff);
         pcm_l_ff <= quantize(v_l_ff, depth_mode_ff);
         pcm_r_ff <= quantize(v_r_ff, depth_mode_ff);
      end
   end

   always_comb begin
      peak_l_in = peak_l_ff;
      peak_r_in = peak_r_ff;
      case (cmd_ff)
         CMD_CLEAR: begin
            peak_l_in = '0;
            peak_r_in = '0;
         end
         CMD_EXPORT: begin
            if (in_range_ff && (mag_l_ff > peak_l_ff)) peak_l_in = mag_l_ff;
            if (in_range_ff && (mag_r_ff > peak_r_ff)) peak_r_in = mag_r_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_l_ff <= '0;
         peak_r_ff <= '0;
      end else if (ctl.fin) begin
         peak_l_ff <= peak_l_in;
         peak_r_ff <= peak_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fin) begin
         rsp_pcm_left_ff   <= exported ? pcm_l_ff : '0;
         rsp_pcm_right_ff  <= exported ? pcm_r_ff : '0;
         rsp_peak_left_ff  <= peak_l_in;
         rsp_peak_right_ff <= peak_r_in;
         rsp_status_ff     <= (cmd_ff inside {CMD_MIX, CMD_EXPORT}) && !in_range_ff;
      end
   end

   assign rsp_pcm_left   = rsp_pcm_left_ff;
   assign rsp_pcm_right  = rsp_pcm_right_ff;
   assign rsp_peak_left  = rsp_peak_left_ff;
   assign rsp_peak_right = rsp_peak_right_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/stereo_mix_bus_dither_quantizer.sv =====
// stereo mix bus with dithered pcm export
//
// req channel: one item per command (clear, mix, export) with the frame
// index, both source samples, the gain and four dither values.
// rsp channel: one item back for every req item, carrying both pcm samples,
// both peak registers as they stand after the command, and a status bit
// set when a mix or export addresses a frame at or beyond frame_count.
// csr channel: frame_count (index 0) and depth_mode (index 1), always ready;
// write only while no item is in flight.
// a mix or export in range passes a registered read of the bus memory,
// one multiply stage and one add/quantize stage, then a write-back in the
// cycle the result is loaded. an unused command or a frame out of range
// skips the read and arithmetic stages and goes to loading its result.
// req_ready is back once the result is loaded.
// a clear sweeps both stores one frame a cycle, then loads its result.
// after reset the same sweep runs over every frame with req_ready low.
// a result waits in the output register while the receiver stalls; the
// next item may be accepted meanwhile but its result holds until the
// register is taken.
module stereo_mix_bus_dither_quantizer
   import mixq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CMD_W-1:0]            req_command,
   input  logic [IDX_W-1:0]            req_frame_index,
   input  logic signed [SAMPLE_W-1:0]  req_left_in,
   input  logic signed [SAMPLE_W-1:0]  req_right_in,
   input  logic [GAIN_W-1:0]           req_gain,
   input  logic signed [DITHER_W-1:0]  req_dither_left_a,
   input  logic signed [DITHER_W-1:0]  req_dither_left_b,
   input  logic signed [DITHER_W-1:0]  req_dither_right_a,
   input  logic signed [DITHER_W-1:0]  req_dither_right_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [PCM_W-1:0]     rsp_pcm_left,
   output logic signed [PCM_W-1:0]     rsp_pcm_right,
   output logic [PEAK_W-1:0]           rsp_peak_left,
   output logic [PEAK_W-1:0]           rsp_peak_right,
   output logic                        rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   ctl_cmd_type   ctl;
   dp_status_type stat;

   assign csr_ready = 1'b1;

   mixq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   mixq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_command        (req_command),
      .req_frame_index    (req_frame_index),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_gain           (req_gain),
      .req_dither_left_a  (req_dither_left_a),
      .req_dither_left_b  (req_dither_left_b),
      .req_dither_right_a (req_dither_right_a),
      .req_dither_right_b (req_dither_right_b),
      .rsp_pcm_left       (rsp_pcm_left),
      .rsp_pcm_right      (rsp_pcm_right),
      .rsp_peak_left      (rsp_peak_left),
      .rsp_peak_right     (rsp_peak_right),
      .rsp_status         (rsp_status)
   );

   // the bus is swept clean before any item is taken
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in flight");

   // an ignored frame never carries pcm data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_pcm_left == '0 && rsp_pcm_right == '0)
      else $error("pcm data on an ignored frame");

   // quantizer output is clipped symmetrically
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pcm_left != 24'h800000 && rsp_pcm_right != 24'h800000)
      else $error("pcm sample beyond full scale");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mixq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic DEPTH_24 = 1'b0;
   localparam logic DEPTH_16 = 1'b1;
   localparam longint BUS_HI = longint'(BUS_MAX);
   localparam longint BUS_LO = longint'(BUS_MIN);
   localparam longint ONE_Q28 = 64'sd268435456;
   localparam longint DITHER_UNIT = 64'sd1048576;
   localparam int SAMPLE_HI = 8388607;
   localparam int SAMPLE_LO = -8388608;
   localparam int PUMP_MIXES = 530;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD = 400;
   localparam int HOLD_AFTER = 250;
   localparam int MAX_PRINTED = 40;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [CMD_W-1:0]           command;
      logic [IDX_W-1:0]           frame_index;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [GAIN_W-1:0]          gain;
      logic signed [DITHER_W-1:0] dither_left_a;
      logic signed [DITHER_W-1:0] dither_left_b;
      logic signed [DITHER_W-1:0] dither_right_a;
      logic signed [DITHER_W-1:0] dither_right_b;
   } bus_cmd_type;

   typedef struct {
      logic signed [PCM_W-1:0] pcm_left;
      logic signed [PCM_W-1:0] pcm_right;
      logic [PEAK_W-1:0]       peak_l;
      logic [PEAK_W-1:0]       peak_r;
      logic                    status;
   } bus_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = '0;
   logic [IDX_W-1:0]           req_frame_index = '0;
   logic signed [SAMPLE_W-1:0] req_left_in = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic [GAIN_W-1:0]          req_gain = '0;
   logic signed [DITHER_W-1:0] req_dither_left_a = '0;
   logic signed [DITHER_W-1:0] req_dither_left_b = '0;
   logic signed [DITHER_W-1:0] req_dither_right_a = '0;
   logic signed [DITHER_W-1:0] req_dither_right_b = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [PCM_W-1:0]    rsp_pcm_left;
   logic signed [PCM_W-1:0]    rsp_pcm_right;
   logic [PEAK_W-1:0]          rsp_peak_left;
   logic [PEAK_W-1:0]          rsp_peak_right;
   logic                       rsp_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // bus image and register copy kept by the predictor
   longint left_bus[int];
   longint right_bus[int];
   longint left_peak_model = 0;
   longint right_peak_model = 0;
   int     model_frame_count = 0;
   logic   model_depth = DEPTH_24;

   bus_cmd_type    pending_cmds[$];
   bus_result_type expected_bus_results[$];
   bus_cmd_type    offered_cmd;

   int     burst_left = 1;
   int     gap_left = 0;
   int     hold_left = 0;
   bit     long_hold_done = 0;
   int     stall_mode = 0;
   int     stall_left = 0;
   int     results_checked = 0;
   int     error_count = 0;
   longint cycle_count = 0;
   int     n_items = 0, n_mixes = 0, n_exports = 0, n_clears = 0;
   int     n_unused = 0, n_out_of_range = 0, n_saturated = 0, n_clipped = 0;

   stereo_mix_bus_dither_quantizer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_frame_index    (req_frame_index),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_gain           (req_gain),
      .req_dither_left_a  (req_dither_left_a),
      .req_dither_left_b  (req_dither_left_b),
      .req_dither_right_a (req_dither_right_a),
      .req_dither_right_b (req_dither_right_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pcm_left       (rsp_pcm_left),
      .rsp_pcm_right      (rsp_pcm_right),
      .rsp_peak_left      (rsp_peak_left),
      .rsp_peak_right     (rsp_peak_right),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #2 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("mismatch: %s", msg);
   endtask

   task automatic add_pending(input bus_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   function automatic longint mix_into(input longint acc,
                                       input logic signed [SAMPLE_W-1:0] sample,
                                       input logic [GAIN_W-1:0] gain);
      longint sum;
      sum = acc + (longint'(sample) * longint'(gain)) / 512;
      if (sum > BUS_HI) begin
         n_saturated++;
         return BUS_HI;
      end
      if (sum < BUS_LO) begin
         n_saturated++;
         return BUS_LO;
      end
      return sum;
   endfunction

   function automatic logic signed [PCM_W-1:0] quantize_sample(
      input longint bus, input logic signed [DITHER_W-1:0] da,
      input logic signed [DITHER_W-1:0] db, input longint scale);
      longint v, lim;
      v = bus * scale + (longint'(da) + longint'(db)) * DITHER_UNIT;
      lim = scale * ONE_Q28;
      if (v > lim) begin
         n_clipped++;
         return PCM_W'(scale);
      end
      if (v < -lim) begin
         n_clipped++;
         return PCM_W'(-scale);
      end
      return PCM_W'(v / ONE_Q28);
   endfunction

   function automatic longint magnitude(input longint bus);
      if (bus == BUS_LO) return BUS_HI;
      return bus < 0 ? -bus : bus;
   endfunction

   // works out the result of one accepted item and updates the bus image
   task automatic apply_bus_command(input bus_cmd_type c);
      bus_result_type r;
      longint sl, sr, scale;
      int idx;
      bit in_range;
      idx = int'(c.frame_index);
      in_range = idx < model_frame_count;
      sl = left_bus.exists(idx) ? left_bus[idx] : 0;
      sr = right_bus.exists(idx) ? right_bus[idx] : 0;
      r.pcm_left = '0;
      r.pcm_right = '0;
      r.status = 1'b0;
      case (c.command)
         CMD_CLEAR: begin
            left_bus.delete();
            right_bus.delete();
            left_peak_model = 0;
            right_peak_model = 0;
            n_clears++;
         end
         CMD_MIX: begin
            if (in_range) begin
               left_bus[idx] = mix_into(sl, c.left_in, c.gain);
               right_bus[idx] = mix_into(sr, c.right_in, c.gain);
               n_mixes++;
            end else begin
               r.status = 1'b1;
               n_out_of_range++;
            end
         end
         CMD_EXPORT: begin
            if (in_range) begin
               scale = (model_depth == DEPTH_16) ? 32767 : 8388607;
               r.pcm_left = quantize_sample(sl, c.dither_left_a, c.dither_left_b, scale);
               r.pcm_right = quantize_sample(sr, c.dither_right_a, c.dither_right_b, scale);
               if (magnitude(sl) > left_peak_model) left_peak_model = magnitude(sl);
               if (magnitude(sr) > right_peak_model) right_peak_model = magnitude(sr);
               n_exports++;
            end else begin
               r.status = 1'b1;
               n_out_of_range++;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      r.peak_l = PEAK_W'(left_peak_model);
      r.peak_r = PEAK_W'(right_peak_model);
      expected_bus_results.insert(expected_bus_results.size(), r);
      n_items++;
   endtask

   function automatic bus_cmd_type make_cmd(input logic [CMD_W-1:0] command, input int idx,
                                            input int left, input int right, input int gain,
                                            input int dla, input int dlb, input int dra,
                                            input int drb);
      bus_cmd_type c;
      c.command = command;
      c.frame_index = IDX_W'(idx);
      c.left_in = SAMPLE_W'(left);
      c.right_in = SAMPLE_W'(right);
      c.gain = GAIN_W'(gain);
      c.dither_left_a = DITHER_W'(dla);
      c.dither_left_b = DITHER_W'(dlb);
      c.dither_right_a = DITHER_W'(dra);
      c.dither_right_b = DITHER_W'(drb);
      return c;
   endfunction

   function automatic int random_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_HI;
         1: return SAMPLE_LO;
         2: return int'($urandom_range(0, 511)) - 256;
         default: return int'($urandom);
      endcase
   endfunction

   // mostly frames in range, with the edges of frame_count and some anywhere
   function automatic bus_cmd_type random_cmd(input int frames);
      bus_cmd_type c;
      int pick, hot;
      pick = $urandom_range(0, 19);
      hot = frames < 16 ? frames : 16;
      c = make_cmd(CMD_MIX, 0, random_sample(), random_sample(), 0, $urandom, $urandom,
                   $urandom, $urandom);
      if (pick == 0) c.command = CMD_UNUSED;
      else if (pick > 10) c.command = CMD_EXPORT;
      pick = $urandom_range(0, 9);
      if (hot > 0 && pick <= 5) c.frame_index = IDX_W'($urandom_range(0, hot - 1));
      else if (frames > 0 && pick == 6) c.frame_index = IDX_W'(frames - 1);
      else if (frames < FRAMES && pick == 7) c.frame_index = IDX_W'(frames);
      else c.frame_index = IDX_W'($urandom);
      case ($urandom_range(0, 9))
         0: c.gain = '0;
         1: c.gain = '1;
         2: c.gain = GAIN_W'(16384);
         3, 4, 5: c.gain = GAIN_W'($urandom_range(0, 4095));
         default: c.gain = GAIN_W'($urandom);
      endcase
      return c;
   endfunction

   task automatic queue_random(input int count, input bit with_clear);
      bus_cmd_type c;
      int clear_at;
      clear_at = with_clear ? int'($urandom_range(0, count - 1)) : -1;
      for (int k = 0; k < count; k++) begin
         c = random_cmd(model_frame_count);
         if (k == clear_at) c.command = CMD_CLEAR;
         add_pending(c);
      end
   endtask

   // drive one frame into saturation with full-scale mixes, then back off
   task automatic queue_pump(input int frame, input bit rising);
      bus_cmd_type c;
      for (int k = 0; k < PUMP_MIXES; k++) begin
         c = random_cmd(model_frame_count);
         c.command = CMD_MIX;
         c.frame_index = IDX_W'(frame);
         c.left_in = rising ? SAMPLE_W'(SAMPLE_HI) : SAMPLE_W'(SAMPLE_LO);
         c.right_in = rising ? SAMPLE_W'(SAMPLE_LO) : SAMPLE_W'(SAMPLE_HI);
         c.gain = '1;
         add_pending(c);
         if (k % 48 == 47 || k >= PUMP_MIXES - 3) begin
            c.command = CMD_EXPORT;
            add_pending(c);
         end
      end
      for (int k = 0; k < 6; k++) begin
         c = random_cmd(model_frame_count);
         c.command = CMD_MIX;
         c.frame_index = IDX_W'(frame);
         c.left_in = SAMPLE_W'(rising ? -int'($urandom_range(1, SAMPLE_HI))
                                      : int'($urandom_range(1, SAMPLE_HI)));
         c.right_in = -c.left_in;
         add_pending(c);
         c.command = CMD_EXPORT;
         add_pending(c);
      end
   endtask

   // both registers are written on every call, valid held across the pair
   task automatic configure(input int frames, input logic depth);
      csr_index <= REG_FRAME_COUNT;
      csr_data <= CSR_DATA_W'(frames);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      model_frame_count = frames;
      csr_index <= REG_DEPTH_MODE;
      csr_data <= CSR_DATA_W'(depth);
      do @(posedge clock); while (!csr_ready);
      model_depth = depth;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_bus_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_bus_command(offered_cmd);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               offered_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_command <= offered_cmd.command;
               req_frame_index <= offered_cmd.frame_index;
               req_left_in <= offered_cmd.left_in;
               req_right_in <= offered_cmd.right_in;
               req_gain <= offered_cmd.gain;
               req_dither_left_a <= offered_cmd.dither_left_a;
               req_dither_left_b <= offered_cmd.dither_left_b;
               req_dither_right_a <= offered_cmd.dither_right_a;
               req_dither_right_b <= offered_cmd.dither_right_b;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) < 2) begin
                  burst_left = $urandom_range(80, 250);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = $urandom_range(0, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result item and stalls on its own pattern
   always @(posedge clock) begin
      bus_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bus_results.size() == 0) begin
               flag_error($sformatf("result %0d arrived with nothing expected",
                                    results_checked));
            end else begin
               want = expected_bus_results.pop_front();
               if (rsp_pcm_left !== want.pcm_left)
                  flag_error($sformatf("result %0d pcm_left %0d, want %0d",
                                       results_checked, rsp_pcm_left, want.pcm_left));
               if (rsp_pcm_right !== want.pcm_right)
                  flag_error($sformatf("result %0d pcm_right %0d, want %0d",
                                       results_checked, rsp_pcm_right, want.pcm_right));
               if (rsp_peak_left !== want.peak_l)
                  flag_error($sformatf("result %0d left peak %0h, want %0h",
                                       results_checked, rsp_peak_left, want.peak_l));
               if (rsp_peak_right !== want.peak_r)
                  flag_error($sformatf("result %0d right peak %0h, want %0h",
                                       results_checked, rsp_peak_right, want.peak_r));
               if (rsp_status !== want.status)
                  flag_error($sformatf("result %0d status %0b, want %0b",
                                       results_checked, rsp_status, want.status));
            end
            results_checked++;
         end
         // one long hold-off so the pipeline backs up into req_ready
         if (!long_hold_done && results_checked == HOLD_AFTER) begin
            long_hold_done = 1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (stall_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout: %0d results still outstanding", expected_bus_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      configure(16, DEPTH_24);

      // empty frames with dither extremes, full-scale and zero-gain mixes,
      // out-of-range frames, unused command, clipping and truncation
      add_pending(make_cmd(CMD_EXPORT, 0, 0, 0, 0, -128, -128, -128, -128));
      add_pending(make_cmd(CMD_EXPORT, 0, 0, 0, 0, 127, 127, 127, 127));
      add_pending(make_cmd(CMD_MIX, 0, SAMPLE_HI, SAMPLE_LO, 65535, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 15, SAMPLE_LO, SAMPLE_HI, 16384, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 1, 123456, -654321, 0, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 2, 1, -1, 65535, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 3, 4194304, -4194304, 16384, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 16, SAMPLE_HI, SAMPLE_HI, 65535, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 65535, SAMPLE_LO, SAMPLE_LO, 65535, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_EXPORT, 16, 0, 0, 0, 127, 127, 127, 127));
      add_pending(make_cmd(CMD_EXPORT, 65535, 0, 0, 0, -128, -128, -128, -128));
      add_pending(make_cmd(CMD_UNUSED, 0, SAMPLE_HI, SAMPLE_LO, 65535,
                           127, -128, 127, -128));
      add_pending(make_cmd(CMD_EXPORT, 0, 0, 0, 0, -128, -128, -128, -128));
      add_pending(make_cmd(CMD_EXPORT, 15, 0, 0, 0, 127, 127, 127, 127));
      add_pending(make_cmd(CMD_EXPORT, 1, 0, 0, 0, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_EXPORT, 2, 0, 0, 0, -128, -128, 127, 127));
      add_pending(make_cmd(CMD_EXPORT, 3, 0, 0, 0, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_EXPORT, 3, 0, 0, 0, 127, 127, -128, -128));
      add_pending(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_EXPORT, 0, 0, 0, 0, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_MIX, 0, -1, 1, 1, 0, 0, 0, 0));
      add_pending(make_cmd(CMD_EXPORT, 0, 0, 0, 0, -128, -128, -128, -128));
      drain();

      configure(16, DEPTH_16);
      queue_random(180, 1);
      drain();
      configure(16, DEPTH_24);
      queue_pump(5, 1);
      drain();
      configure(16, DEPTH_16);
      queue_pump(9, 0);
      drain();
      configure(FRAMES, DEPTH_24);
      queue_random(220, 1);
      drain();
      configure(0, DEPTH_16);
      queue_random(40, 0);
      drain();
      configure($urandom_range(1, 64), 1'($urandom_range(0, 1)));
      queue_random(180, 1);
      drain();
      configure(FRAMES, DEPTH_16);
      queue_random(180, 1);
      drain();
      configure(17, DEPTH_24);
      queue_random(100, 0);
      drain();

      if (expected_bus_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_bus_results.size()));
      $display("ran %0d items: %0d mixes, %0d exports, %0d clears, %0d unused, %0d out of range",
               n_items, n_mixes, n_exports, n_clears, n_unused, n_out_of_range);
      $display("bus sums saturated %0d times, pcm clipped %0d times, %0d errors",
               n_saturated, n_clipped, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
